// ===== rtl/fir32_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, coefficient table and coefficient scaling for the 32-tap FIR filter.
package fir32_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int BASE_FRAC = 15;
   localparam int NUM_COEFS = 32;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Symmetric taps, quantized to signed Q1.15 (round half away from zero)
   localparam int COEF_Q15 [NUM_COEFS] = '{
        255,  -235,  1917,   521, -1320, -2621, -2270,     5,
       2678,  3412,  1177, -2520, -4648, -3211,   859,  4317,
       4317,   859, -3211, -4648, -2520,  1177,  3412,  2678,
          5, -2270, -2621, -1320,   521,  1917,  -235,   255
   };

   // Tap k of the Q1.15 table; taps past the table are zero
   function automatic int coef_at(input int k);
      int c;
      c = 0;
      if (k < NUM_COEFS) begin
         c = COEF_Q15[k];
      end
      return c;
   endfunction

   // Rescale a Q1.15 value to frac fractional bits; narrowing truncates toward zero
   function automatic int scale_coef(input int c, input int frac);
      int r;
      int sh;
      r  = c;
      sh = 0;
      if (frac >= BASE_FRAC) begin
         sh = frac - BASE_FRAC;
         r  = c <<< sh;
      end else begin
         sh = BASE_FRAC - frac;
         if (c < 0) begin
            r = -((-c) >>> sh);
         end else begin
            r = c >>> sh;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/fir32_taps.sv =====
`timescale 1ns / 1ps
// Delay line of recent samples and the registered per-tap product stage.
module fir32_taps
   import fir32_pkg::*;
#(
   parameter int TAPS           = 32,
   parameter int COEF_FRAC_BITS = 15,
   parameter int PROD_W         = 33
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  sample_type               sample,
   input  logic                     prod_en,
   output logic signed [PROD_W-1:0] prod_ff [TAPS]
);

   localparam int COEF_W = COEF_FRAC_BITS + 2;

   sample_type taps_ff [TAPS];

   // Newest sample enters at tap 0; older ones move one place down
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            taps_ff[k] <= '0;
         end
      end else if (shift_en) begin
         taps_ff[0] <= sample;
         for (int k = 1; k < TAPS; k++) begin
            taps_ff[k] <= taps_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < TAPS; k++) begin : g_mul
      localparam logic signed [COEF_W-1:0] TAP_C =
         COEF_W'(scale_coef(coef_at(k), COEF_FRAC_BITS));

      always_ff @(posedge clock) begin
         if (prod_en) begin
            prod_ff[k] <= PROD_W'(taps_ff[k]) * PROD_W'(TAP_C);
         end
      end
   end

endmodule

// ===== rtl/fir32_tree.sv =====
`timescale 1ns / 1ps
// Registered binary adder tree over the tap products, one level per stage.
module fir32_tree #(
   parameter int TAPS   = 32,
   parameter int PROD_W = 33,
   parameter int LEVELS = 5,
   parameter int ACC_W  = 38
) (
   input  logic                     clock,
   input  logic [LEVELS-1:0]        level_en,
   input  logic signed [PROD_W-1:0] prod [TAPS],
   output logic signed [ACC_W-1:0]  sum
);

   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = LEAVES - 1;

   logic signed [ACC_W-1:0] leaf  [LEAVES];
   logic signed [ACC_W-1:0] node_ff [NODES];

   // Pad the leaf row with zeros up to a power of two
   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < TAPS) begin : g_used
         assign leaf[j] = ACC_W'(prod[j]);
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   // Heap order: node i sums children 2i+1 and 2i+2; the root is node 0
   for (genvar i = 0; i < NODES; i++) begin : g_node
      localparam int D = $clog2(i + 2) - 1;
      logic signed [ACC_W-1:0] lhs;
      logic signed [ACC_W-1:0] rhs;

      if (2 * i + 1 >= NODES) begin : g_from_leaf
         assign lhs = leaf[2*i+1-NODES];
         assign rhs = leaf[2*i+2-NODES];
      end else begin : g_from_node
         assign lhs = node_ff[2*i+1];
         assign rhs = node_ff[2*i+2];
      end

      always_ff @(posedge clock) begin
         if (level_en[D]) begin
            node_ff[i] <= lhs + rhs;
         end
      end
   end

   assign sum = node_ff[0];

endmodule

// ===== rtl/fir32_out.sv =====
`timescale 1ns / 1ps
// Output stage: scale the accumulator down, truncate toward zero, saturate.
module fir32_out
   import fir32_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 15,
   parameter int ACC_W          = 38
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [ACC_W-1:0] acc,
   output sample_type              sample_ff
);

   localparam logic signed [ACC_W:0] BIAS  = (ACC_W+1)'((64'sd1 <<< COEF_FRAC_BITS) - 1);
   localparam logic signed [ACC_W:0] Y_MAX = (ACC_W+1)'(SAMPLE_MAX);
   localparam logic signed [ACC_W:0] Y_MIN = (ACC_W+1)'(SAMPLE_MIN);

   logic signed [ACC_W:0] biased;
   logic signed [ACC_W:0] scaled;
   sample_type            sample_in;

   always_comb begin
      // Add 2^F-1 to negatives so the arithmetic shift rounds toward zero
      biased = (acc < 0) ? ((ACC_W+1)'(acc) + BIAS) : (ACC_W+1)'(acc);
      scaled = biased >>> COEF_FRAC_BITS;
      priority if (scaled > Y_MAX) begin
         sample_in = sample_type'(SAMPLE_MAX);
      end else if (scaled < Y_MIN) begin
         sample_in = sample_type'(SAMPLE_MIN);
      end else begin
         sample_in = scaled[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_in;
      end
   end

endmodule

// ===== rtl/fir_filter_32tap_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one transfer per cycle while the output is not stalled; the sample
// register, product stage, one stage per adder-tree level and the output register
// each hold their own item.
// Reset (synchronous, active high) clears the delay line to zero and empties
// every stage; no response is pending after reset.
module fir_filter_32tap_unit
   import fir32_pkg::*;
#(
   parameter int TAPS           = 32,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_sample_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output sample_type rsp_sample_out
);

   localparam int LEVELS = $clog2(TAPS);
   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + LEVELS;
   // Stage 0: delay line, 1: products, 2..LEVELS+1: tree levels, last: output
   localparam int NST    = LEVELS + 3;

   logic [NST-1:0]          vld_ff;
   logic [NST-1:0]          vld_in;
   logic [NST-1:0]          free;
   logic [NST-1:0]          load;
   logic [LEVELS-1:0]       level_en;
   logic signed [PROD_W-1:0] prod [TAPS];
   logic signed [ACC_W-1:0] acc;

   // Stage s can take a new item when it is empty or its item moves on.
   // Bubbles collapse, so the input fills empty stages while a result waits.
   always_comb begin
      free[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int s = NST - 2; s >= 0; s--) begin
         free[s] = !vld_ff[s] || free[s+1];
      end
      load[0] = req_valid && free[0];
      for (int s = 1; s < NST; s++) begin
         load[s] = vld_ff[s-1] && free[s];
      end
      for (int s = 0; s < NST - 1; s++) begin
         vld_in[s] = load[s] || (vld_ff[s] && !free[s+1]);
      end
      vld_in[NST-1] = load[NST-1] || (vld_ff[NST-1] && rsp_stall);
      // Tree depth d sits at stage LEVELS+1-d
      for (int d = 0; d < LEVELS; d++) begin
         level_en[d] = load[LEVELS+1-d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !free[0];
   assign rsp_valid = vld_ff[NST-1];

   fir32_taps #(
      .TAPS           (TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .PROD_W         (PROD_W)
   ) u_taps (
      .clock    (clock),
      .reset    (reset),
      .shift_en (load[0]),
      .sample   (req_sample_in),
      .prod_en  (load[1]),
      .prod_ff  (prod)
   );

   fir32_tree #(
      .TAPS   (TAPS),
      .PROD_W (PROD_W),
      .LEVELS (LEVELS),
      .ACC_W  (ACC_W)
   ) u_tree (
      .clock    (clock),
      .level_en (level_en),
      .prod     (prod),
      .sum      (acc)
   );

   fir32_out #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_W          (ACC_W)
   ) u_out (
      .clock     (clock),
      .load      (load[NST-1]),
      .acc       (acc),
      .sample_ff (rsp_sample_out)
   );

   // Hold off the input only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("input stalled with an empty stage");

   // An accepted transfer lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted sample lost");

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("stage valid after reset");

   // A stalled result holds its value until the transfer
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("output register overwritten while stalled");

endmodule

// ===== test/fir_filter_32tap_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 32-tap direct-form FIR filter unit.
module fir_filter_32tap_unit_tb;
   import fir32_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int TAP_COUNT      = 32;
   localparam int FRAC_BITS      = 15;
   localparam int RANDOM_ITEMS   = 1030;
   localparam int DIRECTED_ROWS  = 22;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   // Filter taps in Q1.15, kept here on their own so a wrong table in the block shows up
   localparam int TAP_COEF [TAP_COUNT] = '{
        255,  -235,  1917,   521, -1320, -2621, -2270,     5,
       2678,  3412,  1177, -2520, -4648, -3211,   859,  4317,
       4317,   859, -3211, -4648, -2520,  1177,  3412,  2678,
          5, -2270, -2621, -1320,   521,  1917,  -235,   255
   };

   typedef enum int {
      SEQ_UNIFORM,
      SEQ_EXTREME,
      SEQ_SAT_HIGH,
      SEQ_SAT_LOW,
      SEQ_SMALL,
      SEQ_IMPULSE
   } seq_kind_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   // One directed row: the sample, and a typed-in result where it is obvious
   typedef struct packed {
      sample_type sample;
      logic       fixed;
      sample_type result;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   sample_type req_sample_in;
   logic       rsp_valid;
   logic       rsp_stall;
   sample_type rsp_sample_out;

   // Side data that travels with the sample in flight (directed rows only)
   logic       row_fixed;
   sample_type row_result;

   // Predictor state: our own copy of the delay line and its write pointer
   sample_type  hist [TAP_COUNT];
   logic [4:0]  wr_ptr;

   sample_type   filtered_q [$];
   int           error_count;
   int           idle_cycles;
   int           burst_left;
   stim_row_type dir_rows [DIRECTED_ROWS];

   fir_filter_32tap_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Store the sample at the write pointer, sum the newest 32 taps, scale down
   // with truncation toward zero, clamp to 16 bits, then advance the pointer.
   function automatic sample_type filter_step(input sample_type x);
      longint     acc;
      longint     y;
      logic [4:0] idx;
      acc = 0;
      hist[wr_ptr] = x;
      idx = wr_ptr;
      for (int k = 0; k < TAP_COUNT; k++) begin
         acc += longint'(hist[idx]) * longint'(TAP_COEF[k]);
         idx = idx - 5'd1;
      end
      // SystemVerilog integer division already truncates toward zero
      y = acc / (longint'(1) << FRAC_BITS);
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
      end
      if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
      end
      wr_ptr = wr_ptr + 5'd1;
      return sample_type'(y);
   endfunction

   // Drive one sample at the falling edge and hold it until the transfer.
   // Bursts of random length are broken up by random gaps, some of them zero.
   task automatic send_sample(input sample_type s, input logic fixed, input sample_type res);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= s;
      row_fixed     <= fixed;
      row_result    <= res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(negedge clock);
   endtask

   // Feed 32 samples whose signs line up with the taps (or against them), so the
   // newest output lands far outside 16 bits and must clamp; then a short tail.
   task automatic send_sat_run(input logic low_side, output int sent);
      int         k;
      int         tail;
      logic       pos;
      logic       full;
      sample_type s;
      tail = $urandom_range(0, 8);
      for (int j = 0; j < TAP_COUNT; j++) begin
         k    = TAP_COUNT - 1 - j;
         pos  = (TAP_COEF[k] > 0) ^ low_side;
         full = ($urandom_range(0, 3) != 0);
         if (pos) begin
            s = full ? sample_type'(SAMPLE_MAX)
                     : sample_type'(SAMPLE_MAX - int'($urandom_range(0, 3000)));
         end else begin
            s = full ? sample_type'(SAMPLE_MIN)
                     : sample_type'(SAMPLE_MIN + int'($urandom_range(0, 3000)));
         end
         send_sample(s, 1'b0, '0);
      end
      for (int j = 0; j < tail; j++) begin
         send_sample(sample_type'($urandom), 1'b0, '0);
      end
      sent = TAP_COUNT + tail;
   endtask

   // Receiver: pick a stall pattern, keep it for a random stretch, then switch.
   // Stretches with no stall at all are part of the mix.
   initial begin : rsp_stall_gen
      stall_kind_type kind;
      int             stretch;
      int             period;
      int             duty;
      int             phase;
      rsp_stall = 1'b0;
      forever begin
         kind    = stall_kind_type'($urandom_range(0, 3));
         stretch = $urandom_range(20, 200);
         period  = $urandom_range(2, 16);
         duty    = $urandom_range(1, period - 1);
         phase   = 0;
         repeat (stretch) begin
            @(negedge clock);
            case (kind)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 9) < 2);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 9) < 8);
               end
               default: begin
                  rsp_stall <= (phase < duty);
               end
            endcase
            phase = (phase + 1 >= period) ? 0 : phase + 1;
         end
      end
   end

   // Sample both channels at the rising edge. Check the result transfer against
   // the oldest expectation first, then queue the expectation for a new input.
   // The watchdog counts edges on which neither channel transfers.
   always @(posedge clock) begin
      sample_type want;
      logic       moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (filtered_q.size() == 0) begin
               $display("%0t ERROR: result %0d with nothing expected", $time, rsp_sample_out);
               error_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_sample_out !== want) begin
                  $display("%0t ERROR: sample_out expected %0d actual %0d",
                           $time, want, rsp_sample_out);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want  = filter_step(req_sample_in);
            filtered_q.push_back(row_fixed ? row_result : want);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ERROR: no transfer for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      seq_kind_type kind;
      int           len;
      int           rand_sent;
      logic         paused;
      sample_type   s;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_in = '0;
      row_fixed     = 1'b0;
      row_result    = '0;
      error_count   = 0;
      idle_cycles   = 0;
      burst_left    = 0;
      rand_sent     = 0;
      paused        = 1'b0;
      wr_ptr        = '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
         hist[i] = '0;
      end

      // First row: -1 into a cleared line gives -255 / 2^15, which truncates
      // toward zero to 0 rather than flooring to -1.
      dir_rows = '{
         '{-1,     1'b1, 0},
         '{32767,  1'b0, 0},
         '{-32768, 1'b0, 0},
         '{0,      1'b0, 0},
         '{1,      1'b0, 0},
         '{-1,     1'b0, 0},
         '{21845,  1'b0, 0},
         '{-21846, 1'b0, 0},
         '{-2,     1'b0, 0},
         '{255,    1'b0, 0},
         '{-256,   1'b0, 0},
         '{32767,  1'b0, 0},
         '{32767,  1'b0, 0},
         '{32767,  1'b0, 0},
         '{-32768, 1'b0, 0},
         '{-32768, 1'b0, 0},
         '{-32768, 1'b0, 0},
         '{12345,  1'b0, 0},
         '{-12345, 1'b0, 0},
         '{0,      1'b0, 0},
         '{0,      1'b0, 0},
         '{16384,  1'b0, 0}
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed rows: extremes, alternating bit patterns, small values near zero
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_sample(dir_rows[i].sample, dir_rows[i].fixed, dir_rows[i].result);
      end
      drain_outputs();

      // Random part: a mix of sequence shapes, with the tap-aligned runs that
      // drive the sum into saturation taking a large share.
      while (rand_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: kind = SEQ_UNIFORM;
            3:       kind = SEQ_EXTREME;
            4, 5:    kind = SEQ_SAT_HIGH;
            6, 7:    kind = SEQ_SAT_LOW;
            8:       kind = SEQ_SMALL;
            default: kind = SEQ_IMPULSE;
         endcase
         case (kind)
            SEQ_SAT_HIGH: begin
               send_sat_run(1'b0, len);
               rand_sent += len;
            end
            SEQ_SAT_LOW: begin
               send_sat_run(1'b1, len);
               rand_sent += len;
            end
            SEQ_IMPULSE: begin
               len = $urandom_range(8, 40);
               for (int j = 0; j < len; j++) begin
                  if (j == 0) begin
                     s = $urandom_range(0, 1) ? sample_type'(SAMPLE_MAX)
                                              : sample_type'(SAMPLE_MIN);
                  end else begin
                     s = '0;
                  end
                  send_sample(s, 1'b0, '0);
               end
               rand_sent += len;
            end
            default: begin
               len = $urandom_range(4, 40);
               for (int j = 0; j < len; j++) begin
                  case (kind)
                     SEQ_EXTREME: begin
                        case ($urandom_range(0, 4))
                           0:       s = sample_type'(SAMPLE_MAX);
                           1:       s = sample_type'(SAMPLE_MIN);
                           2:       s = '0;
                           3:       s = '1;
                           default: s = sample_type'(1);
                        endcase
                     end
                     SEQ_SMALL: begin
                        s = sample_type'(int'($urandom_range(0, 200)) - 100);
                     end
                     default: begin
                        s = sample_type'($urandom);
                     end
                  endcase
                  send_sample(s, 1'b0, '0);
               end
               rand_sent += len;
            end
         endcase
         // Pause once mid-run until the pipeline has fully emptied
         if (!paused && rand_sent > RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            drain_outputs();
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
